@@ src/pfe_pkg.sv @@
// Shared constants and types for the programmable state machine engine.
package pfe_pkg;

  localparam int MAX_STATES  = 16;
  localparam int MAX_TRANS   = 64;
  localparam int SIGNAL_BITS = 8;

  localparam int SIG_W      = SIGNAL_BITS + 1;
  localparam int ST_W       = $clog2(MAX_STATES);
  localparam int TR_W       = $clog2(MAX_TRANS);
  localparam int ST_CNT_W   = $clog2(MAX_STATES + 1);
  localparam int TR_CNT_W   = $clog2(MAX_TRANS + 1);
  localparam int ENTRY_W    = 2 * ST_W + SIG_W;

  localparam logic [SIG_W-1:0]    SIG_DFLT     = {SIG_W{1'b1}};
  localparam logic [ST_CNT_W-1:0] ST_LIMIT     = ST_CNT_W'(MAX_STATES);
  localparam logic [TR_CNT_W-1:0] TR_LIMIT     = TR_CNT_W'(MAX_TRANS);

  typedef enum logic [1:0] {
    MODE_ADD_STATE = 2'd0,
    MODE_ADD_TRANS = 2'd1,
    MODE_SIGNAL    = 2'd2,
    MODE_FORCE     = 2'd3
  } mode_t;

  typedef struct packed {
    logic [ST_W-1:0]  src;
    logic [ST_W-1:0]  tgt;
    logic [SIG_W-1:0] sig;
  } entry_t;

endpackage

@@ src/pfe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module pfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/programmable_fsm_engine.sv @@
// Top level of the programmable state machine engine.
//
//   channel | ports                                      | handshake
//   --------+--------------------------------------------+--------------------------
//   input   | in_mode, in_accept_flag, in_from_state,    | start high, busy low
//           | in_to_state, in_signal_value               |
//   result  | out_new_id .. out_transition_count         | out_valid, one cycle
//
// Add state, force, and a signal with no current state skip the table scan and
// strobe after the S_SCAN state. Add transition, and a signal with a current state,
// first scan the transition table RAM, read one entry per cycle over all stored
// entries with registered read data.
// A new item is accepted in the cycle the result strobe shows.
// rst_n clears counts and the current state; table contents stay undefined.
// The receiver cannot stall; results are never held.
module programmable_fsm_engine
  import pfe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic                in_accept_flag,
  input  logic [3:0]          in_from_state,
  input  logic [3:0]          in_to_state,
  input  logic signed [8:0]   in_signal_value,
  output logic                out_valid,
  output logic [5:0]          out_new_id,
  output logic                out_ok,
  output logic                out_matched,
  output logic                out_current_valid,
  output logic [3:0]          out_cur_state,
  output logic                out_is_accepting,
  output logic [3:0]          out_dflt_state,
  output logic [4:0]          out_state_count,
  output logic [6:0]          out_transition_count
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t               state_r, state_nxt;
  mode_t                mode_r;
  logic                 acc_r;
  logic [ST_W-1:0]      from_r, to_r;
  logic [SIG_W-1:0]     sig_r;

  logic [ST_CNT_W-1:0]  ns_r, ns_nxt;
  logic [TR_CNT_W-1:0]  nt_r, nt_nxt;
  logic [ST_W-1:0]      cur_r, cur_nxt;
  logic                 has_r, has_nxt;
  logic                 marks_r [MAX_STATES];

  logic [TR_CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic                 dup_r, dup_nxt;
  logic                 hit_r, hit_nxt;
  logic                 dflt_r, dflt_nxt;
  logic [ST_W-1:0]      hit_tgt_r, hit_tgt_nxt;
  logic [ST_W-1:0]      dflt_tgt_r, dflt_tgt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [5:0]           new_id_r, new_id_nxt;
  logic                 ok_r, ok_nxt;
  logic                 matched_r, matched_nxt;
  logic                 is_acc_r, is_acc_nxt;

  logic                 accept;
  logic [TR_CNT_W-1:0]  scan_len;
  logic                 issue;
  logic                 done;
  logic                 mark_we;
  logic                 ram_we;
  entry_t               ram_wdata;
  entry_t               ram_rdata;
  logic [ENTRY_W-1:0]   ram_rbits;

  assign accept   = start && (state_r == S_IDLE);
  assign scan_len = ((mode_r == MODE_ADD_TRANS) || (mode_r == MODE_SIGNAL && has_r)) ?
                    nt_r : '0;
  assign issue    = (state_r == S_SCAN) && (rd_cnt_r < scan_len);
  assign done     = (state_r == S_SCAN) && !issue && !pend_r;
  assign ram_rdata = entry_t'(ram_rbits);
  assign ram_wdata = '{src: from_r, tgt: to_r, sig: sig_r};

  pfe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TRANS)
  ) u_trans_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (nt_r[TR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[TR_W-1:0]),
    .rdata (ram_rbits)
  );

  always_comb begin
    state_nxt     = state_r;
    ns_nxt        = ns_r;
    nt_nxt        = nt_r;
    cur_nxt       = cur_r;
    has_nxt       = has_r;
    rd_cnt_nxt    = rd_cnt_r;
    pend_nxt      = issue;
    dup_nxt       = dup_r;
    hit_nxt       = hit_r;
    dflt_nxt      = dflt_r;
    hit_tgt_nxt   = hit_tgt_r;
    dflt_tgt_nxt  = dflt_tgt_r;
    out_valid_nxt = 1'b0;
    new_id_nxt    = new_id_r;
    ok_nxt        = ok_r;
    matched_nxt   = matched_r;
    is_acc_nxt    = is_acc_r;
    mark_we       = 1'b0;
    ram_we        = 1'b0;

    if (accept) begin
      state_nxt  = S_SCAN;
      rd_cnt_nxt = '0;
      dup_nxt    = 1'b0;
      hit_nxt    = 1'b0;
      dflt_nxt   = 1'b0;
    end

    if (issue) begin
      rd_cnt_nxt = rd_cnt_r + 1'b1;
    end

    if (pend_r) begin
      if (ram_rdata.src == from_r && ram_rdata.tgt == to_r) begin
        dup_nxt = 1'b1;
      end
      if (!hit_r && ram_rdata.src == cur_r && ram_rdata.sig == sig_r) begin
        hit_nxt     = 1'b1;
        hit_tgt_nxt = ram_rdata.tgt;
      end
      if (ram_rdata.src == cur_r && ram_rdata.sig == SIG_DFLT) begin
        dflt_nxt     = 1'b1;
        dflt_tgt_nxt = ram_rdata.tgt;
      end
    end

    if (done) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      new_id_nxt    = '0;
      ok_nxt        = 1'b0;
      matched_nxt   = 1'b0;
      case (mode_r)
        MODE_ADD_STATE: begin
          if (ns_r < ST_LIMIT) begin
            new_id_nxt = 6'(ns_r);
            mark_we    = 1'b1;
            if (ns_r == '0) begin
              cur_nxt = '0;
              has_nxt = 1'b1;
            end
            ns_nxt = ns_r + 1'b1;
            ok_nxt = 1'b1;
          end
        end
        MODE_ADD_TRANS: begin
          if (ST_CNT_W'(from_r) < ns_r && ST_CNT_W'(to_r) < ns_r &&
              nt_r < TR_LIMIT && !dup_r) begin
            new_id_nxt = 6'(nt_r);
            ram_we     = 1'b1;
            nt_nxt     = nt_r + 1'b1;
            ok_nxt     = 1'b1;
          end
        end
        MODE_SIGNAL: begin
          if (has_r) begin
            if (hit_r) begin
              cur_nxt     = hit_tgt_r;
              matched_nxt = 1'b1;
            end else if (dflt_r) begin
              cur_nxt = dflt_tgt_r;
            end
          end
        end
        MODE_FORCE: begin
          if (ST_CNT_W'(to_r) < ns_r) begin
            cur_nxt = to_r;
            has_nxt = 1'b1;
            ok_nxt  = 1'b1;
          end
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
      if (mark_we && ns_r == '0) begin
        is_acc_nxt = acc_r;
      end else begin
        is_acc_nxt = has_nxt && marks_r[cur_nxt];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ns_r        <= '0;
      nt_r        <= '0;
      cur_r       <= '0;
      has_r       <= 1'b0;
      rd_cnt_r    <= '0;
      pend_r      <= 1'b0;
      dup_r       <= 1'b0;
      hit_r       <= 1'b0;
      dflt_r      <= 1'b0;
      out_valid_r <= 1'b0;
      new_id_r    <= '0;
      ok_r        <= 1'b0;
      matched_r   <= 1'b0;
      is_acc_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ns_r        <= ns_nxt;
      nt_r        <= nt_nxt;
      cur_r       <= cur_nxt;
      has_r       <= has_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pend_r      <= pend_nxt;
      dup_r       <= dup_nxt;
      hit_r       <= hit_nxt;
      dflt_r      <= dflt_nxt;
      out_valid_r <= out_valid_nxt;
      new_id_r    <= new_id_nxt;
      ok_r        <= ok_nxt;
      matched_r   <= matched_nxt;
      is_acc_r    <= is_acc_nxt;
    end
    if (accept) begin
      mode_r <= mode_t'(in_mode);
      acc_r  <= in_accept_flag;
      from_r <= ST_W'(in_from_state);
      to_r   <= ST_W'(in_to_state);
      sig_r  <= SIG_W'(in_signal_value);
    end
    hit_tgt_r  <= hit_tgt_nxt;
    dflt_tgt_r <= dflt_tgt_nxt;
    if (mark_we) begin
      marks_r[ns_r[ST_W-1:0]] <= acc_r;
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_new_id           = new_id_r;
  assign out_ok               = ok_r;
  assign out_matched          = matched_r;
  assign out_current_valid    = has_r;
  assign out_cur_state        = 4'(cur_r);
  assign out_is_accepting     = is_acc_r;
  assign out_dflt_state       = '0;
  assign out_state_count      = 5'(ns_r);
  assign out_transition_count = 7'(nt_r);

endmodule

@@ src/pfe_checker.sv @@
// Port-level checks for the programmable state machine engine, bound to the top level.
module pfe_checker
  import pfe_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_ok,
  input logic       out_matched,
  input logic       out_current_valid,
  input logic [3:0] out_cur_state,
  input logic [4:0] out_state_count,
  input logic [6:0] out_transition_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result strobe while busy or on consecutive cycles");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_state_count <= 5'(MAX_STATES) &&
                   out_transition_count <= 7'(MAX_TRANS)))
    else $error("count beyond table size");

  a_no_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_current_valid) |-> (out_cur_state == '0 && !out_matched))
    else $error("current state reported without a state");

  a_match_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_matched) |-> !out_ok)
    else $error("matched signal also reported ok");

endmodule

bind programmable_fsm_engine pfe_checker u_pfe_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_ok               (out_ok),
  .out_matched          (out_matched),
  .out_current_valid    (out_current_valid),
  .out_cur_state        (out_cur_state),
  .out_state_count      (out_state_count),
  .out_transition_count (out_transition_count)
);
